// ===== rtl/bwn_pkg.sv =====
// Shared constants for the bone weight top-N normalizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bwn_pkg;

    localparam int BONE_W         = 8;
    localparam int WEIGHT_W       = 16;
    localparam int OUT_SLOTS      = 4;
    localparam int INFLUENCES_DEF = 4;
    localparam int BONE_COUNT     = 256;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUO_STEPS      = 16;
    localparam int IN_DATA_W      = BONE_W + WEIGHT_W;
    localparam int OUT_DATA_W     = OUT_SLOTS * (BONE_W + WEIGHT_W);

    localparam logic [WEIGHT_W-1:0] ONE_Q15 = 16'h8000;

endpackage

`default_nettype wire

// ===== rtl/bone_weight_top4_normalizer_top.sv =====
// Bone weight top-N normalizer: keeps the strongest bone influences of a vertex and
// scales them to sum to 1.0 in Q1.15.
//
// Input stream: one request per bone/weight pair. s_axis_tdata holds the bone index
// and the raw weight, s_axis_tuser says whether the request carries a pair at all and
// s_axis_tlast closes the vertex. A vertex without pairs is one request with tuser low
// and tlast high. The front end takes one request per cycle while its queue of closed
// vertices has room; s_axis_tready drops only when that queue is full.
// Output stream: one request per vertex on m_axis_tdata with four bones and four
// normalized weights, strongest first.
// From the closing request to m_axis_tvalid, the back end picks the record up from
// the queue, sums the kept weights, divides each slot in turn in the shared
// bit-serial divider, which sets the vertex rate, and loads the output register.
// When the sum is zero the divider is bypassed. Pairs are taken at one per cycle
// while the queue has room, so the input can take the next vertex while the back
// end still works on earlier ones. When the receiver stalls, the finished vertex
// waits in the output register while the back end works on the next queued vertex;
// the queue then fills and finally stalls the input. Reset empties the queue, drops
// any open vertex and clears m_axis_tvalid.
`default_nettype none

module bone_weight_top4_normalizer_top #(
    parameter int INFLUENCES = bwn_pkg::INFLUENCES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: bone_index [7:0], weight [23:8].
    input  wire logic [bwn_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: has_pair.
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Fields from bit 0: bone_a, bone_b, bone_c, bone_d (8 bits each),
    // weight_a, weight_b, weight_c, weight_d (16 bits each).
    output logic [bwn_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import bwn_pkg::*;

    localparam int REC_W = INFLUENCES * (BONE_W + WEIGHT_W);

    logic                                w_accept;
    logic                                w_push;
    logic                                w_pop;
    logic                                w_q_full;
    logic                                w_q_empty;
    logic [INFLUENCES-1:0][BONE_W-1:0]   w_front_bones, w_back_bones;
    logic [INFLUENCES-1:0][WEIGHT_W-1:0] w_front_wts, w_back_wts;
    logic [REC_W-1:0]                    w_q_in, w_q_out;

    // The input is held off only by a full queue of closed vertices.
    assign s_axis_tready = !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bwn_front #(
        .INFLUENCES (INFLUENCES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_has_pair (s_axis_tuser),
        .i_bone     (s_axis_tdata[BONE_W-1:0]),
        .i_weight   (s_axis_tdata[BONE_W +: WEIGHT_W]),
        .i_last     (s_axis_tlast),
        .o_push     (w_push),
        .o_bones    (w_front_bones),
        .o_weights  (w_front_wts)
    );

    // A record holds the bones in its low part and the weights above them.
    assign w_q_in       = {w_front_wts, w_front_bones};
    assign w_back_bones = w_q_out[INFLUENCES*BONE_W-1:0];
    assign w_back_wts   = w_q_out[REC_W-1:INFLUENCES*BONE_W];

    bwn_queue #(
        .DATA_W (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    bwn_back #(
        .INFLUENCES (INFLUENCES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_bones   (w_back_bones),
        .i_weights (w_back_wts),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

    // The front end never closes a vertex into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("vertex record pushed into a full queue");

    // Normalized weights never add up to more than 1.0.
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((18'(m_axis_tdata[47:32]) + 18'(m_axis_tdata[63:48])
            + 18'(m_axis_tdata[79:64]) + 18'(m_axis_tdata[95:80])) <= 18'(ONE_Q15)))
        else $error("normalized weights exceed 1.0");

    // Division by a common sum keeps the slots in descending order.
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[47:32] >= m_axis_tdata[63:48])
            && (m_axis_tdata[63:48] >= m_axis_tdata[79:64])
            && (m_axis_tdata[79:64] >= m_axis_tdata[95:80])))
        else $error("output weights not in descending order");

endmodule

`default_nettype wire

// ===== rtl/bwn_front.sv =====
// Front end: saturates and range-checks incoming pairs, keeps the sorted slots of
// the open vertex and pushes one closed vertex record per last item. Uses bwn_pkg.
`default_nettype none

module bwn_front #(
    parameter int INFLUENCES = bwn_pkg::INFLUENCES_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_accept,
    input  wire logic                                      i_has_pair,
    input  wire logic [bwn_pkg::BONE_W-1:0]                i_bone,
    input  wire logic [bwn_pkg::WEIGHT_W-1:0]              i_weight,
    input  wire logic                                      i_last,
    output logic                                           o_push,
    output logic [INFLUENCES-1:0][bwn_pkg::BONE_W-1:0]     o_bones,
    output logic [INFLUENCES-1:0][bwn_pkg::WEIGHT_W-1:0]   o_weights
);
    import bwn_pkg::*;

    localparam int FILL_W = $clog2(INFLUENCES + 1);

    logic [INFLUENCES-1:0][BONE_W-1:0]   r_bones, n_bones;
    logic [INFLUENCES-1:0][WEIGHT_W-1:0] r_wts, n_wts;
    logic [FILL_W-1:0]                   r_filled, n_filled;
    logic [WEIGHT_W-1:0]                 w_sat;
    logic [FILL_W-1:0]                   w_pos;
    logic                                w_ins;

    always_comb begin
        w_sat = (i_weight > ONE_Q15) ? ONE_Q15 : i_weight;
        // Slots are sorted, so the ones that hold at least the new weight form a prefix.
        w_pos = '0;
        for (int i = 0; i < INFLUENCES; i++) begin
            if ((FILL_W'(i) < r_filled) && (r_wts[i] >= w_sat)) begin
                w_pos = w_pos + 1'b1;
            end
        end
        w_ins = i_accept && i_has_pair && (32'(i_bone) < BONE_COUNT)
                && (w_pos < FILL_W'(INFLUENCES));

        n_bones  = r_bones;
        n_wts    = r_wts;
        n_filled = r_filled;
        if (w_ins) begin
            if (r_filled < FILL_W'(INFLUENCES)) begin
                n_filled = r_filled + 1'b1;
            end
            for (int i = 1; i < INFLUENCES; i++) begin
                if (FILL_W'(i) > w_pos) begin
                    n_bones[i] = r_bones[i-1];
                    n_wts[i]   = r_wts[i-1];
                end
            end
            for (int i = 0; i < INFLUENCES; i++) begin
                if (FILL_W'(i) == w_pos) begin
                    n_bones[i] = i_bone;
                    n_wts[i]   = w_sat;
                end
            end
        end

        // An unbound vertex closes as bone 0 at full weight.
        o_bones   = n_bones;
        o_weights = n_wts;
        if (n_filled == '0) begin
            o_bones[0]   = '0;
            o_weights[0] = ONE_Q15;
        end
        o_push = i_accept && i_last;

        if (o_push) begin
            n_bones  = '0;
            n_wts    = '0;
            n_filled = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bones  <= '0;
            r_wts    <= '0;
            r_filled <= '0;
        end else begin
            r_bones  <= n_bones;
            r_wts    <= n_wts;
            r_filled <= n_filled;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bwn_queue.sv =====
// Small FIFO of closed vertex records between the front and back ends.
// Uses bwn_pkg for its depth.
`default_nettype none

module bwn_queue #(
    parameter int DATA_W = 96
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [DATA_W-1:0]      o_data
);
    import bwn_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bwn_back.sv =====
// Back end: sums the kept weights of one vertex, divides each by a nonzero sum with a
// shared bit-serial divider and holds the result in an output register. Uses bwn_pkg.
`default_nettype none

module bwn_back #(
    parameter int INFLUENCES = bwn_pkg::INFLUENCES_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_q_empty,
    input  wire logic [INFLUENCES-1:0][bwn_pkg::BONE_W-1:0]   i_bones,
    input  wire logic [INFLUENCES-1:0][bwn_pkg::WEIGHT_W-1:0] i_weights,
    output logic                                           o_pop,
    output logic                                           o_valid,
    input  wire logic                                      i_ready,
    output logic [bwn_pkg::OUT_DATA_W-1:0]                 o_data
);
    import bwn_pkg::*;

    localparam int IDX_W  = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;
    localparam int SUM_W  = 15 + $clog2(INFLUENCES + 1);
    localparam int STEP_W = $clog2(QUO_STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                          r_state, n_state;
    logic [INFLUENCES-1:0][BONE_W-1:0]   r_bones, n_bones;
    logic [INFLUENCES-1:0][WEIGHT_W-1:0] r_wts, n_wts;
    logic [IDX_W-1:0]                    r_k, n_k;
    logic [SUM_W-1:0]                    r_sum, n_sum;
    logic [SUM_W-1:0]                    r_rem, n_rem;
    logic                                r_nb, n_nb;
    logic [STEP_W-1:0]                   r_step, n_step;
    logic [WEIGHT_W-1:0]                 r_quo, n_quo;
    logic                                r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]               r_out_data, n_out_data;
    logic [OUT_DATA_W-1:0]               w_result;
    logic [SUM_W:0]                      w_trial;
    logic                                w_ge;
    logic                                w_last_k;

    genvar g;
    generate
        for (g = 0; g < OUT_SLOTS; g++) begin : g_slot
            if (g < INFLUENCES) begin : g_used
                assign w_result[g*BONE_W +: BONE_W] = r_bones[g];
                assign w_result[OUT_SLOTS*BONE_W + g*WEIGHT_W +: WEIGHT_W] = r_wts[g];
            end else begin : g_empty
                assign w_result[g*BONE_W +: BONE_W] = '0;
                assign w_result[OUT_SLOTS*BONE_W + g*WEIGHT_W +: WEIGHT_W] = '0;
            end
        end
    endgenerate

    assign w_trial  = {r_rem, r_nb};
    assign w_ge     = (w_trial >= {1'b0, r_sum});
    assign w_last_k = (r_k == IDX_W'(INFLUENCES - 1));
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_bones     = r_bones;
        n_wts       = r_wts;
        n_k         = r_k;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_nb        = r_nb;
        n_step      = r_step;
        n_quo       = r_quo;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_bones = i_bones;
                    n_wts   = i_weights;
                    n_k     = '0;
                    n_sum   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_sum = r_sum + SUM_W'(r_wts[r_k]);
                if (w_last_k) begin
                    n_k     = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_LOAD: begin
                if (r_sum == '0) begin
                    // Nothing to normalize by: weights stay as they are.
                    if (w_last_k) begin
                        n_state = ST_OUT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    // Numerator is w << 15; its top part w >> 1 is below the sum.
                    n_rem   = {{(SUM_W-WEIGHT_W+1){1'b0}}, r_wts[r_k][WEIGHT_W-1:1]};
                    n_nb    = r_wts[r_k][0];
                    n_step  = '0;
                    n_quo   = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_rem  = w_ge ? SUM_W'(w_trial - {1'b0, r_sum}) : SUM_W'(w_trial);
                n_quo  = {r_quo[WEIGHT_W-2:0], w_ge};
                n_nb   = 1'b0;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(QUO_STEPS - 1)) begin
                    n_wts[r_k] = {r_quo[WEIGHT_W-2:0], w_ge};
                    if (w_last_k) begin
                        n_state = ST_OUT;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_data  = w_result;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bones    <= n_bones;
        r_wts      <= n_wts;
        r_k        <= n_k;
        r_sum      <= n_sum;
        r_rem      <= n_rem;
        r_nb       <= n_nb;
        r_step     <= n_step;
        r_quo      <= n_quo;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
